### design/gyro_fused_wheel_odometry_assert.svh
// Assertion macros for the gyro fused wheel odometry block.
// Expects clk_i and rst_ni in the scope that uses them; empty when SYNTH is set.
`ifndef GYRO_FUSED_WHEEL_ODOMETRY_ASSERT_SVH
`define GYRO_FUSED_WHEEL_ODOMETRY_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define GFWO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define GFWO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GFWO_ASSERT_NOW(lbl, ante, cons, msg)
`define GFWO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/gfwo_pkg.sv
// Package for the gyro fused wheel odometry block: payload structs, register
// indexes, microcode format and program, CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gfwo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam int PC_W         = 4;

  // limit gain 1/K in Q4.30
  localparam logic signed [33:0] CORDIC_X0 = 34'sh0_26DD_3B6A;

  typedef struct packed {
    logic signed [15:0] left_ticks;
    logic signed [15:0] right_ticks;
    logic signed [15:0] gyro_yaw;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic               gyro_chosen;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_DIST_PER_TICK = 3'd0,
    REG_HEAD_PER_TICK = 3'd1,
    REG_THRESHOLD     = 3'd2,
    REG_INIT_X        = 3'd3,
    REG_INIT_Y        = 3'd4,
    REG_INIT_HEADING  = 3'd5
  } cfg_reg_e;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SUM_DPT,
    MUL_DIFF_HPT,
    MUL_DS_COS,
    MUL_DS_SIN
  } mul_sel_e;

  // branch conditions: taken -> target, else fall through
  typedef enum logic [2:0] {
    BR_NEVER,
    BR_ALWAYS,
    BR_NO_INPUT,
    BR_ROT_MORE,
    BR_OUT_BUSY
  } br_cond_e;

  typedef struct packed {
    logic            take_in;
    mul_sel_e        mul;
    logic            ld_ds;
    logic            setup;
    logic            rot;
    logic            upd_x;
    logic            put;
    br_cond_e        cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] STEP_WAIT    = 4'd0;
  localparam logic [PC_W-1:0] STEP_MUL_DS  = 4'd1;
  localparam logic [PC_W-1:0] STEP_MUL_ODO = 4'd2;
  localparam logic [PC_W-1:0] STEP_SETUP   = 4'd3;
  localparam logic [PC_W-1:0] STEP_ROT     = 4'd4;
  localparam logic [PC_W-1:0] STEP_MUL_COS = 4'd5;
  localparam logic [PC_W-1:0] STEP_MUL_SIN = 4'd6;
  localparam logic [PC_W-1:0] STEP_HOLD    = 4'd7;
  localparam logic [PC_W-1:0] STEP_PUT     = 4'd8;

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{take_in: 1'b0, mul: MUL_NONE, ld_ds: 1'b0, setup: 1'b0, rot: 1'b0,
          upd_x: 1'b0, put: 1'b0, cond: BR_NEVER, target: STEP_WAIT};
    unique case (pc)
      STEP_WAIT: begin
        w.take_in = 1'b1;
        w.cond    = BR_NO_INPUT;
        w.target  = STEP_WAIT;
      end
      STEP_MUL_DS:  w.mul = MUL_SUM_DPT;
      STEP_MUL_ODO: begin
        w.ld_ds = 1'b1;
        w.mul   = MUL_DIFF_HPT;
      end
      STEP_SETUP:   w.setup = 1'b1;
      STEP_ROT: begin
        w.rot    = 1'b1;
        w.cond   = BR_ROT_MORE;
        w.target = STEP_ROT;
      end
      STEP_MUL_COS: w.mul = MUL_DS_COS;
      STEP_MUL_SIN: begin
        w.mul   = MUL_DS_SIN;
        w.upd_x = 1'b1;
      end
      STEP_HOLD: begin
        w.cond   = BR_OUT_BUSY;
        w.target = STEP_HOLD;
      end
      STEP_PUT: begin
        w.put    = 1'b1;
        w.cond   = BR_ALWAYS;
        w.target = STEP_WAIT;
      end
      default: begin
        w.cond   = BR_ALWAYS;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

  // atan(2^-i) as 32-bit binary angle
  function automatic logic signed [33:0] atan_ang(input logic [4:0] i);
    logic signed [33:0] a;
    unique case (i)
      5'd0:  a = 34'sh2000_0000;
      5'd1:  a = 34'sh12E4_051E;
      5'd2:  a = 34'sh09FB_385B;
      5'd3:  a = 34'sh0511_11D4;
      5'd4:  a = 34'sh028B_0D43;
      5'd5:  a = 34'sh0145_D7E1;
      5'd6:  a = 34'sh00A2_F61E;
      5'd7:  a = 34'sh0051_7C55;
      5'd8:  a = 34'sh0028_BE53;
      5'd9:  a = 34'sh0014_5F2F;
      5'd10: a = 34'sh000A_2F98;
      5'd11: a = 34'sh0005_17CC;
      5'd12: a = 34'sh0002_8BE6;
      5'd13: a = 34'sh0001_45F3;
      5'd14: a = 34'sh0000_A2FA;
      5'd15: a = 34'sh0000_517D;
      5'd16: a = 34'sh0000_28BE;
      5'd17: a = 34'sh0000_145F;
      5'd18: a = 34'sh0000_0A30;
      5'd19: a = 34'sh0000_0518;
      5'd20: a = 34'sh0000_028C;
      5'd21: a = 34'sh0000_0146;
      5'd22: a = 34'sh0000_00A3;
      5'd23: a = 34'sh0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### design/gyro_fused_wheel_odometry.sv
// Gyro fused wheel odometry: one transaction in, one pose transaction out.
// Steps per item: accept in the wait step, multiply the tick sum by distance per tick and
// the tick difference by heading per tick, set up and run CORDIC_STEPS CORDIC rotations,
// multiply by cos and sin on the shared multiplier, hold while a result waits, then put.
// One item at a time. Reset: sequencer to the wait step, pose, last yaw, registers cleared.
// Depends on gfwo_pkg and gyro_fused_wheel_odometry_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "gyro_fused_wheel_odometry_assert.svh"

module gyro_fused_wheel_odometry (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire gfwo_pkg::in_item_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output gfwo_pkg::out_item_t     out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i
);
  import gfwo_pkg::*;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

  // sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          cw;
  logic            br;

  // config
  logic [31:0] dpt_q, hpt_q;
  logic [14:0] thr_q;

  // state
  logic signed [31:0] pose_x_q, pose_y_q;
  logic signed [15:0] pose_h_q, last_yaw_q;

  // datapath
  in_item_t           in_q;
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] mul_p, p_q;
  logic signed [17:0] ds_q;
  logic signed [16:0] lr_sum, lr_diff;
  logic signed [50:0] ds_rnd, odo_rnd, dd_rnd;
  logic [16:0]        odo17, chg17, chg_q;
  logic [15:0]        gyro_d, disc, mag, mid, ang;
  logic               moved, use_gyro, gyro_q;
  logic signed [33:0] cx_q, cy_q, cz_q, cos_v, sin_v, xs, ys;
  logic [ITER_W-1:0]  iter_q;
  logic               flip_q;
  logic signed [20:0] dd;
  logic signed [32:0] x_sum, y_sum;
  logic signed [31:0] x_sat, y_sat;
  logic               accept, out_busy;
  out_item_t          out_q;
  logic               out_valid_q;

  assign cw         = ucode(pc_q);
  assign in_ready_o = cw.take_in;
  assign accept     = in_valid_i & in_ready_o;
  assign out_busy   = out_valid_q & ~out_ready_i;

  always_comb begin
    unique case (cw.cond)
      BR_NEVER:    br = 1'b0;
      BR_ALWAYS:   br = 1'b1;
      BR_NO_INPUT: br = ~in_valid_i;
      BR_ROT_MORE: br = (iter_q != ITER_LAST);
      BR_OUT_BUSY: br = out_busy;
      default:     br = 1'b1;
    endcase
    pc_d = br ? cw.target : pc_q + PC_W'(1);
  end

  // shared multiplier
  assign lr_sum  = 17'(in_q.left_ticks) + 17'(in_q.right_ticks);
  assign lr_diff = 17'(in_q.right_ticks) - 17'(in_q.left_ticks);
  assign cos_v   = flip_q ? -cx_q : cx_q;
  assign sin_v   = flip_q ? -cy_q : cy_q;

  always_comb begin
    unique case (cw.mul)
      MUL_SUM_DPT: begin
        mul_a = 18'(lr_sum);
        mul_b = $signed({1'b0, dpt_q});
      end
      MUL_DIFF_HPT: begin
        mul_a = 18'(lr_diff);
        mul_b = $signed({1'b0, hpt_q});
      end
      MUL_DS_COS: begin
        mul_a = ds_q;
        mul_b = $signed(cos_v[32:0]);
      end
      MUL_DS_SIN: begin
        mul_a = ds_q;
        mul_b = $signed(sin_v[32:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // rounding, half up
  assign ds_rnd  = p_q + 51'sh1_0000_0000;
  assign odo_rnd = p_q + 51'sd32768;
  assign dd_rnd  = p_q + 51'sh2000_0000;
  assign odo17   = odo_rnd[32:16];
  assign dd      = dd_rnd[50:30];

  // heading source selection; wheel change kept to 17 bits for the half step
  assign gyro_d   = in_q.gyro_yaw - last_yaw_q;
  assign disc     = odo17[15:0] - gyro_d;
  assign mag      = disc[15] ? (~disc + 16'd1) : disc;
  assign moved    = (in_q.left_ticks != '0) || (in_q.right_ticks != '0);
  assign use_gyro = (mag > {1'b0, thr_q}) && moved;
  assign chg17    = use_gyro ? {gyro_d[15], gyro_d} : odo17;
  assign mid      = pose_h_q + chg17[16:1];
  // outside [-pi/2, pi/2): rotate by pi, negate results
  assign ang      = (mid[15] != mid[14]) ? {~mid[15], mid[14:0]} : mid;

  assign xs = cx_q >>> iter_q;
  assign ys = cy_q >>> iter_q;

  assign x_sum = 33'(pose_x_q) + 33'(dd);
  assign y_sum = 33'(pose_y_q) + 33'(dd);
  assign x_sat = (x_sum[32] != x_sum[31]) ?
                 (x_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : x_sum[31:0];
  assign y_sat = (y_sum[32] != y_sum[31]) ?
                 (y_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : y_sum[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_WAIT;
      iter_q      <= '0;
      dpt_q       <= '0;
      hpt_q       <= '0;
      thr_q       <= '0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      pose_h_q    <= '0;
      last_yaw_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cw.setup) begin
        iter_q     <= '0;
        last_yaw_q <= in_q.gyro_yaw;
      end else if (cw.rot && iter_q != ITER_LAST) begin
        iter_q <= iter_q + ITER_W'(1);
      end
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_DIST_PER_TICK: dpt_q    <= cfg_data_i;
          REG_HEAD_PER_TICK: hpt_q    <= cfg_data_i;
          REG_THRESHOLD:     thr_q    <= cfg_data_i[14:0];
          REG_INIT_X:        pose_x_q <= cfg_data_i;
          REG_INIT_Y:        pose_y_q <= cfg_data_i;
          REG_INIT_HEADING:  pose_h_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end else begin
        if (cw.upd_x) pose_x_q <= x_sat;
        if (cw.put) begin
          pose_y_q <= y_sat;
          pose_h_q <= pose_h_q + chg_q[15:0];
        end
      end
      priority if (cw.put)     out_valid_q <= 1'b1;
      else if (out_ready_i)    out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    if (cw.mul != MUL_NONE) p_q <= mul_p;
    if (cw.ld_ds) ds_q <= ds_rnd[50:33];
    if (cw.setup) begin
      chg_q  <= chg17;
      gyro_q <= use_gyro;
      flip_q <= (mid[15] != mid[14]);
      cx_q   <= CORDIC_X0;
      cy_q   <= '0;
      cz_q   <= {{2{ang[15]}}, ang, 16'h0000};
    end else if (cw.rot) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - atan_ang(5'(iter_q));
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + atan_ang(5'(iter_q));
      end
    end
    if (cw.put) begin
      out_q.pos_x       <= pose_x_q;
      out_q.pos_y       <= y_sat;
      out_q.heading     <= pose_h_q + chg_q[15:0];
      out_q.gyro_chosen <= gyro_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `GFWO_ASSERT_NEXT(a_one_in_flight, accept, !in_ready_o, "input taken while busy")
  `GFWO_ASSERT_NOW(a_put_slot_free, pc_q == STEP_PUT, !out_valid_q, "result overwritten")
  `GFWO_ASSERT_NEXT(a_put_done, pc_q == STEP_PUT, out_valid_q && pc_q == STEP_WAIT, "put failed")
  `GFWO_ASSERT_NEXT(a_rot_start, pc_q == STEP_SETUP, iter_q == '0 && pc_q == STEP_ROT, "bad rot start")

endmodule

`default_nettype wire
